// ===== hdl/qte_pkg.sv =====
// Shared constants, types and helper functions of the quaternion to Euler unit.
package qte_pkg;

   localparam int FRACTION_BITS = 14;
   localparam int ELEM_W        = 16;
   localparam int PROD_W        = 32;
   localparam int CORDIC_STEPS  = 28;
   localparam int SQRT_STAGES   = 32;
   localparam int SQRT_IN_W     = 63;
   localparam int SQRT_OUT_W    = 32;
   localparam int NORM_OUT_W    = 40;
   localparam int CORDIC_W      = 44;
   localparam int ANGLE_W       = 34;
   localparam int ANGLE_FRAC    = 30;
   localparam int OUT_FRAC      = 13;
   localparam int ROLL_W        = 16;
   localparam int PITCH_W       = 15;
   localparam int YAW_W         = 16;
   localparam int IN_DATA_W     = 64;
   localparam int OUT_DATA_W    = 48;
   localparam int ROUND_SHIFT   = ANGLE_FRAC - OUT_FRAC;

   typedef logic signed [ANGLE_W-1:0] angle_type;

   typedef struct packed {
      logic yneg;
      logic xneg;
      logic zero;
   } quad_type;

   localparam angle_type PI_Q30      = 34'sd3373259426;
   localparam angle_type HALF_PI_Q30 = 34'sd1686629713;

   // Width of the signed atan2 operands for a given fraction width.
   function automatic int sum_width(input int fb);
      return ((2 * fb > 33) ? 2 * fb : 33) + 2;
   endfunction

   function automatic int norm_width(input int dw);
      return (dw > 41) ? dw : 41;
   endfunction

   function automatic int norm_stages(input int dw);
      return $clog2(norm_width(dw));
   endfunction

   function automatic int atan_latency(input int dw);
      return norm_stages(dw) + CORDIC_STEPS + 3;
   endfunction

   function automatic angle_type atan_entry(input int i);
      angle_type r;
      unique case (i)
         0:  r = 34'sh3243F6A8;
         1:  r = 34'sh1DAC6705;
         2:  r = 34'sh0FADBAFC;
         3:  r = 34'sh07F56EA6;
         4:  r = 34'sh03FEAB76;
         5:  r = 34'sh01FFD55B;
         6:  r = 34'sh00FFFAAA;
         7:  r = 34'sh007FFF55;
         8:  r = 34'sh003FFFEA;
         9:  r = 34'sh001FFFFD;
         10: r = 34'sh000FFFFF;
         11: r = 34'sh0007FFFF;
         12: r = 34'sh0003FFFF;
         13: r = 34'sh0001FFFF;
         14: r = 34'sh0000FFFF;
         15: r = 34'sh00007FFF;
         16: r = 34'sh00003FFF;
         17: r = 34'sh00001FFF;
         18: r = 34'sh00000FFF;
         19: r = 34'sh000007FF;
         20: r = 34'sh000003FF;
         21: r = 34'sh000001FF;
         22: r = 34'sh000000FF;
         23: r = 34'sh0000007F;
         24: r = 34'sh0000003F;
         25: r = 34'sh0000001F;
         26: r = 34'sh0000000F;
         27: r = 34'sh00000008;
         default: r = '0;
      endcase
      return r;
   endfunction

   // Round a Q30 angle to Q2.13, ties away from zero.
   function automatic logic [ROLL_W-1:0] round_angle(input angle_type a);
      logic [ANGLE_W-1:0] m;
      logic [ANGLE_W-1:0] r;
      m = a[ANGLE_W-1] ? ANGLE_W'(-a) : ANGLE_W'(a);
      r = (m + (ANGLE_W'(1) << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
      return a[ANGLE_W-1] ? ROLL_W'(-r[ROLL_W-1:0]) : r[ROLL_W-1:0];
   endfunction

endpackage

// ===== hdl/quaternion_to_euler_zyx_unit.sv =====
// Quaternion to ZYX Euler angles: top level with the pipeline and output register.
// Throughput: one request per cycle unless the response stalls; the integer square root
// is 32 stages, each CORDIC is 28 stages, and the operand normalization takes clog2 of its
// width. A stalled response freezes every stage at once, so nothing is lost or repeated.
// Reset (synchronous, active high) clears all valid bits and sets scalar_last to 0.
module quaternion_to_euler_zyx_unit #(
   parameter int FRACTION_BITS = qte_pkg::FRACTION_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   // element_0 [15:0], element_1 [31:16], element_2 [47:32], element_3 [63:48]
   input  logic [qte_pkg::IN_DATA_W-1:0]      req_tdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // roll_angle [15:0], pitch_angle [30:16], yaw_angle [46:31], zero [47]
   output logic [qte_pkg::OUT_DATA_W-1:0]     rsp_tdata,
   // pitch_clamped [0]
   output logic                               rsp_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_wr_en,
   input  logic                               csr_wr_data
);

   localparam int SW = qte_pkg::sum_width(FRACTION_BITS);
   localparam int AL = qte_pkg::atan_latency(SW);
   localparam int EW = qte_pkg::ELEM_W;

   logic scalar_last_ff;
   logic rsp_valid_ff;
   logic en;

   // Advance the whole pipeline whenever the output register can take a result.
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         scalar_last_ff <= 1'b0;
      end else if (csr_wr_en) begin
         scalar_last_ff <= csr_wr_data;
      end
   end

   // Front end: products, then atan2 operands and the clamped pitch sine.
   logic                           f_valid, f_clamped;
   logic signed [SW-1:0]           f_rnum, f_rden, f_ynum, f_yden;
   logic [qte_pkg::SQRT_IN_W-1:0]  f_up, f_dn;

   qte_front #(
      .FRACTION_BITS(FRACTION_BITS),
      .SW(SW)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (req_tvalid),
      .scalar_last(scalar_last_ff),
      .element_0  (req_tdata[EW-1:0]),
      .element_1  (req_tdata[2*EW-1:EW]),
      .element_2  (req_tdata[3*EW-1:2*EW]),
      .element_3  (req_tdata[4*EW-1:3*EW]),
      .out_valid  (f_valid),
      .roll_num   (f_rnum),
      .roll_den   (f_rden),
      .yaw_num    (f_ynum),
      .yaw_den    (f_yden),
      .sqrt_up    (f_up),
      .sqrt_dn    (f_dn),
      .clamped    (f_clamped)
   );

   // Pitch: square roots of 1 + s and 1 - s feed the half-angle atan2.
   logic [qte_pkg::SQRT_OUT_W-1:0] root_up, root_dn;

   qte_isqrt u_sqrt_up (.clock(clock), .en(en), .value_in(f_up), .root_out(root_up));
   qte_isqrt u_sqrt_dn (.clock(clock), .en(en), .value_in(f_dn), .root_out(root_dn));

   // Hold roll and yaw operands, the clamp flag and valid while the roots settle.
   logic                  d1_valid;
   logic [4*SW:0]         d1_data;

   qte_delay #(
      .WIDTH(4 * SW + 1),
      .DEPTH(qte_pkg::SQRT_STAGES)
   ) u_sqrt_align (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (f_valid),
      .in_data  ({f_clamped, f_yden, f_ynum, f_rden, f_rnum}),
      .out_valid(d1_valid),
      .out_data (d1_data)
   );

   qte_pkg::angle_type roll_q30, yaw_q30, half_q30;

   qte_atan2 #(.DW(SW)) u_roll (
      .clock    (clock),
      .en       (en),
      .y_in     (d1_data[SW-1:0]),
      .x_in     (d1_data[2*SW-1:SW]),
      .angle_out(roll_q30)
   );

   qte_atan2 #(.DW(SW)) u_yaw (
      .clock    (clock),
      .en       (en),
      .y_in     (d1_data[3*SW-1:2*SW]),
      .x_in     (d1_data[4*SW-1:3*SW]),
      .angle_out(yaw_q30)
   );

   qte_atan2 #(.DW(SW)) u_pitch (
      .clock    (clock),
      .en       (en),
      .y_in     (SW'($signed({1'b0, root_up}))),
      .x_in     (SW'($signed({1'b0, root_dn}))),
      .angle_out(half_q30)
   );

   // Carry valid and the clamp flag alongside the CORDIC stages.
   logic d2_valid, d2_clamped;

   qte_delay #(
      .WIDTH(1),
      .DEPTH(AL)
   ) u_atan_align (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (d1_valid),
      .in_data  (d1_data[4*SW]),
      .out_valid(d2_valid),
      .out_data (d2_clamped)
   );

   // Output register: pitch is twice the half angle less pi/2, then round all three.
   qte_pkg::angle_type              pitch_q30;
   logic [qte_pkg::ROLL_W-1:0]      roll_ff;
   logic [qte_pkg::PITCH_W-1:0]     pitch_ff;
   logic [qte_pkg::YAW_W-1:0]       yaw_ff;
   logic [qte_pkg::ROLL_W-1:0]      pitch_full;
   logic                            clamp_ff;

   assign pitch_q30  = (half_q30 <<< 1) - qte_pkg::HALF_PI_Q30;
   assign pitch_full = qte_pkg::round_angle(pitch_q30);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= d2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         roll_ff  <= qte_pkg::round_angle(roll_q30);
         pitch_ff <= pitch_full[qte_pkg::PITCH_W-1:0];
         yaw_ff   <= qte_pkg::round_angle(yaw_q30);
         clamp_ff <= d2_clamped;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, yaw_ff, pitch_ff, roll_ff};
   assign rsp_tuser  = clamp_ff;

`ifndef SYNTHESIS
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[30:16]) <= 15'sd12868) &&
                     ($signed(rsp_tdata[30:16]) >= -15'sd12868))
      else $error("pitch outside half pi");

   a_roll_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[15:0]) <= 16'sd25736) &&
                     ($signed(rsp_tdata[15:0]) >= -16'sd25736))
      else $error("roll outside pi");

   a_yaw_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[46:31]) <= 16'sd25736) &&
                     ($signed(rsp_tdata[46:31]) >= -16'sd25736))
      else $error("yaw outside pi");
`endif

endmodule

// ===== hdl/qte_delay.sv =====
// Stallable delay line with reset valid bits and a payload lane.
module qte_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   output logic [WIDTH-1:0] out_data
);

   logic             valid_ff [DEPTH];
   logic [WIDTH-1:0] data_ff  [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_tap
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= (i == 0) ? in_valid : valid_ff[(i == 0) ? 0 : i - 1];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            data_ff[i] <= (i == 0) ? in_data : data_ff[(i == 0) ? 0 : i - 1];
         end
      end
   end

   assign out_valid = valid_ff[DEPTH-1];
   assign out_data  = data_ff[DEPTH-1];

endmodule

// ===== hdl/qte_front.sv =====
// Component ordering, products, atan2 operands and the clamped pitch sine.
module qte_front #(
   parameter int FRACTION_BITS = qte_pkg::FRACTION_BITS,
   parameter int SW = qte_pkg::sum_width(FRACTION_BITS)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  logic                                  in_valid,
   input  logic                                  scalar_last,
   input  logic signed [qte_pkg::ELEM_W-1:0]     element_0,
   input  logic signed [qte_pkg::ELEM_W-1:0]     element_1,
   input  logic signed [qte_pkg::ELEM_W-1:0]     element_2,
   input  logic signed [qte_pkg::ELEM_W-1:0]     element_3,
   output logic                                  out_valid,
   output logic signed [SW-1:0]                  roll_num,
   output logic signed [SW-1:0]                  roll_den,
   output logic signed [SW-1:0]                  yaw_num,
   output logic signed [SW-1:0]                  yaw_den,
   output logic        [qte_pkg::SQRT_IN_W-1:0]  sqrt_up,
   output logic        [qte_pkg::SQRT_IN_W-1:0]  sqrt_dn,
   output logic                                  clamped
);

   localparam int K = (61 - 2 * FRACTION_BITS) / 2;
   localparam logic signed [SW-1:0] ONE = SW'(1) << (2 * FRACTION_BITS);

   logic signed [qte_pkg::ELEM_W-1:0] w, x, y, z;
   logic signed [qte_pkg::PROD_W-1:0] wx_ff, yz_ff, wz_ff, xy_ff, xx_ff, yy_ff, zz_ff;
   logic signed [qte_pkg::PROD_W-1:0] wy_ff, xz_ff;
   logic valid1_ff, valid2_ff;

   always_comb begin
      if (scalar_last) begin
         x = element_0; y = element_1; z = element_2; w = element_3;
      end else begin
         w = element_0; x = element_1; y = element_2; z = element_3;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wx_ff <= w * x;
         yz_ff <= y * z;
         wz_ff <= w * z;
         xy_ff <= x * y;
         xx_ff <= x * x;
         yy_ff <= y * y;
         zz_ff <= z * z;
         wy_ff <= w * y;
         xz_ff <= x * z;
      end
   end

   logic signed [SW-1:0] s_raw, s_sat, up_s, dn_s;
   logic                 s_clip;

   always_comb begin
      s_raw  = (SW'(wy_ff) - SW'(xz_ff)) <<< 1;
      s_sat  = s_raw;
      s_clip = 1'b0;
      priority if (s_raw > ONE) begin
         s_sat  = ONE;
         s_clip = 1'b1;
      end else if (s_raw < -ONE) begin
         s_sat  = -ONE;
         s_clip = 1'b1;
      end
      up_s = ONE + s_sat;
      dn_s = ONE - s_sat;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         roll_num <= (SW'(wx_ff) + SW'(yz_ff)) <<< 1;
         roll_den <= ONE - ((SW'(xx_ff) + SW'(yy_ff)) <<< 1);
         yaw_num  <= (SW'(wz_ff) + SW'(xy_ff)) <<< 1;
         yaw_den  <= ONE - ((SW'(yy_ff) + SW'(zz_ff)) <<< 1);
         sqrt_up  <= qte_pkg::SQRT_IN_W'(unsigned'(up_s)) << (2 * K);
         sqrt_dn  <= qte_pkg::SQRT_IN_W'(unsigned'(dn_s)) << (2 * K);
         clamped  <= s_clip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else if (en) begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
      end
   end

   assign out_valid = valid2_ff;

endmodule

// ===== hdl/qte_isqrt.sv =====
// Pipelined floor integer square root, one result bit per stage.
module qte_isqrt (
   input  logic                              clock,
   input  logic                              en,
   input  logic [qte_pkg::SQRT_IN_W-1:0]     value_in,
   output logic [qte_pkg::SQRT_OUT_W-1:0]    root_out
);

   localparam int W  = qte_pkg::SQRT_IN_W;
   localparam int ST = qte_pkg::SQRT_STAGES;

   logic [W-1:0] v_ff [ST-1];
   logic [W-1:0] r_ff [ST];

   for (genvar i = 0; i < ST; i++) begin : g_step
      localparam logic [W-1:0] BIT = W'(1) << (W - 1 - 2 * i);
      logic [W-1:0] v_prev, r_prev, trial;
      logic         take;

      if (i == 0) begin : g_first
         assign v_prev = value_in;
         assign r_prev = '0;
      end else begin : g_next
         assign v_prev = v_ff[i-1];
         assign r_prev = r_ff[i];
      end

      assign trial = r_prev + BIT;
      assign take  = (v_prev >= trial);

      if (i < ST - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               v_ff[i] <= take ? (v_prev - trial) : v_prev;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[(i < ST - 1) ? i + 1 : 0] <= take ? ((r_prev >> 1) + BIT) : (r_prev >> 1);
         end
      end
   end

   assign root_out = r_ff[0][qte_pkg::SQRT_OUT_W-1:0];

endmodule

// ===== hdl/qte_atan2.sv =====
// Pipelined atan2: magnitudes, block normalization, vectoring CORDIC, quadrant fix.
module qte_atan2 #(
   parameter int DW = qte_pkg::sum_width(qte_pkg::FRACTION_BITS)
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [DW-1:0]     y_in,
   input  logic signed [DW-1:0]     x_in,
   output qte_pkg::angle_type       angle_out
);

   localparam int NW  = qte_pkg::norm_width(DW);
   localparam int NS  = qte_pkg::norm_stages(DW);
   localparam int TOP = NW - 1;
   localparam int N   = qte_pkg::CORDIC_STEPS;
   localparam int CW  = qte_pkg::CORDIC_W;
   localparam int OW  = qte_pkg::NORM_OUT_W;

   logic [DW-1:0] y_mag, x_mag;

   logic [NW-1:0]     ny_ff [NS+1];
   logic [NW-1:0]     nx_ff [NS+1];
   logic [NW-1:0]     nm_ff [NS];
   logic [NS-1:0]     lz_ff [NS+1];
   qte_pkg::quad_type nq_ff [NS+1];

   assign y_mag = y_in[DW-1] ? DW'(-y_in) : DW'(y_in);
   assign x_mag = x_in[DW-1] ? DW'(-x_in) : DW'(x_in);

   always_ff @(posedge clock) begin
      if (en) begin
         ny_ff[0]      <= NW'(y_mag);
         nx_ff[0]      <= NW'(x_mag);
         nm_ff[0]      <= (y_mag > x_mag) ? NW'(y_mag) : NW'(x_mag);
         lz_ff[0]      <= '0;
         nq_ff[0].yneg <= y_in[DW-1];
         nq_ff[0].xneg <= x_in[DW-1];
         nq_ff[0].zero <= (y_in == '0) && (x_in == '0);
      end
   end

   // Shift left by halving amounts until the larger magnitude reaches the top bit.
   for (genvar j = 0; j < NS; j++) begin : g_norm
      localparam int SH = 1 << (NS - 1 - j);
      logic hit;
      assign hit = (nm_ff[j][NW-1 -: SH] == '0);

      always_ff @(posedge clock) begin
         if (en) begin
            ny_ff[j+1] <= hit ? (ny_ff[j] << SH) : ny_ff[j];
            nx_ff[j+1] <= hit ? (nx_ff[j] << SH) : nx_ff[j];
            lz_ff[j+1] <= hit ? (lz_ff[j] | NS'(SH)) : lz_ff[j];
            nq_ff[j+1] <= nq_ff[j];
         end
      end

      if (j < NS - 1) begin : g_mag
         always_ff @(posedge clock) begin
            if (en) begin
               nm_ff[j+1] <= hit ? (nm_ff[j] << SH) : nm_ff[j];
            end
         end
      end
   end

   logic signed [CW-1:0] cx_ff [N];
   logic signed [CW-1:0] cy_ff [N];
   qte_pkg::angle_type   z_ff  [N+1];
   qte_pkg::quad_type    q_ff  [N+1];
   logic [NW-1:0]        ys, xs;
   logic                 wide;

   // Top at bit 39 when the value was already that wide, else at bit 38.
   assign wide = (lz_ff[NS] <= NS'(TOP - 39));
   assign ys   = wide ? (ny_ff[NS] >> (TOP - 39)) : (ny_ff[NS] >> (TOP - 38));
   assign xs   = wide ? (nx_ff[NS] >> (TOP - 39)) : (nx_ff[NS] >> (TOP - 38));

   always_ff @(posedge clock) begin
      if (en) begin
         cx_ff[0] <= $signed(CW'(xs[OW-1:0]));
         cy_ff[0] <= $signed(CW'(ys[OW-1:0]));
         z_ff[0]  <= '0;
         q_ff[0]  <= nq_ff[NS];
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_rot
      logic up;
      assign up = (cy_ff[i] >= 0);

      always_ff @(posedge clock) begin
         if (en) begin
            z_ff[i+1] <= up ? (z_ff[i] + qte_pkg::atan_entry(i))
                            : (z_ff[i] - qte_pkg::atan_entry(i));
            q_ff[i+1] <= q_ff[i];
         end
      end

      if (i < N - 1) begin : g_xy
         always_ff @(posedge clock) begin
            if (en) begin
               cx_ff[i+1] <= up ? (cx_ff[i] + (cy_ff[i] >>> i)) : (cx_ff[i] - (cy_ff[i] >>> i));
               cy_ff[i+1] <= up ? (cy_ff[i] - (cx_ff[i] >>> i)) : (cy_ff[i] + (cx_ff[i] >>> i));
            end
         end
      end
   end

   qte_pkg::angle_type zc;

   always_comb begin
      zc = z_ff[N];
      priority if (zc < 0) begin
         zc = '0;
      end else if (zc > qte_pkg::HALF_PI_Q30) begin
         zc = qte_pkg::HALF_PI_Q30;
      end
      if (q_ff[N].xneg) begin
         zc = qte_pkg::PI_Q30 - zc;
      end
      if (q_ff[N].yneg) begin
         zc = -zc;
      end
      if (q_ff[N].zero) begin
         zc = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         angle_out <= zc;
      end
   end

endmodule

// ===== sim/qte_checker.sv =====
// Checker for the quaternion to Euler unit: predicts angles and compares responses.
module qte_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [qte_pkg::IN_DATA_W-1:0]   req_tdata,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [qte_pkg::OUT_DATA_W-1:0]  rsp_tdata,
   input  logic                            rsp_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic                            csr_wr_en,
   input  logic                            csr_wr_data,
   output int                              error_count,
   output int                              pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [15:0] roll;
      logic [14:0] pitch;
      logic [15:0] yaw;
      logic        clamped;
   } euler_type;

   localparam longint PI_C      = 64'sd3373259426;
   localparam longint HALF_PI_C = 64'sd1686629713;
   localparam longint ATAN_TAB [28] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
      64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
      64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
      64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
      64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008};

   logic      order_w_last;
   euler_type angle_queue[$];

   function automatic longint vec_atan2(longint y, longint x);
      longint ay, ax, m, cx, cy, z, nx;
      ay = (y < 0) ? -y : y;
      ax = (x < 0) ? -x : x;
      z = 0;
      if (ay == 0 && ax == 0) return 0;
      m = (ay > ax) ? ay : ax;
      while (m >= (64'sd1 << 40)) begin
         ay = ay >>> 1; ax = ax >>> 1; m = m >>> 1;
      end
      while (m < (64'sd1 << 38)) begin
         ay = ay << 1; ax = ax << 1; m = m << 1;
      end
      cx = ax;
      cy = ay;
      for (int i = 0; i < 28; i++) begin
         if (cy >= 0) begin
            nx = cx + (cy >>> i);
            cy = cy - (cx >>> i);
            z += ATAN_TAB[i];
         end else begin
            nx = cx - (cy >>> i);
            cy = cy + (cx >>> i);
            z -= ATAN_TAB[i];
         end
         cx = nx;
      end
      if (z < 0) z = 0;
      if (z > HALF_PI_C) z = HALF_PI_C;
      if (x < 0) z = PI_C - z;
      if (y < 0) z = -z;
      return z;
   endfunction

   function automatic longint floor_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return longint'(res);
   endfunction

   function automatic logic [15:0] q30_to_q13(longint a);
      longint m, r;
      m = (a < 0) ? -a : a;
      r = (m + (64'sd1 << 16)) >>> 17;
      return (a < 0) ? 16'(-r) : 16'(r);
   endfunction

   function automatic euler_type quat_to_euler(logic [qte_pkg::IN_DATA_W-1:0] d,
                                               logic w_last);
      longint e [4];
      longint w, x, y, z, one, s, pitch;
      euler_type r;
      for (int i = 0; i < 4; i++) e[i] = longint'($signed(d[16*i +: 16]));
      if (w_last) begin
         x = e[0]; y = e[1]; z = e[2]; w = e[3];
      end else begin
         w = e[0]; x = e[1]; y = e[2]; z = e[3];
      end
      one = 64'sd1 << 28;
      r.clamped = 1'b0;
      s = 2 * (w * y - x * z);
      if (s > one) begin
         s = one; r.clamped = 1'b1;
      end
      if (s < -one) begin
         s = -one; r.clamped = 1'b1;
      end
      // Shift both radicands left by 2k, k = 16, before the square roots.
      pitch = 2 * vec_atan2(floor_sqrt((one + s) << 32), floor_sqrt((one - s) << 32))
              - HALF_PI_C;
      r.roll  = q30_to_q13(vec_atan2(2 * (w * x + y * z), one - 2 * (x * x + y * y)));
      r.pitch = 15'(q30_to_q13(pitch));
      r.yaw   = q30_to_q13(vec_atan2(2 * (w * z + x * y), one - 2 * (y * y + z * z)));
      return r;
   endfunction

   assign pending_count = angle_queue.size();

   always @(posedge clock) begin
      euler_type want;
      if (reset) begin
         order_w_last <= 1'b0;
         error_count  <= 0;
      end else begin
         if (req_tvalid && req_tready) angle_queue.push_back(quat_to_euler(req_tdata, order_w_last));
         if (csr_wr_en) order_w_last <= csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            if (angle_queue.size() == 0) begin
               if (error_count < 10) $display("unexpected response %h", rsp_tdata);
               error_count <= error_count + 1;
            end else begin
               want = angle_queue.pop_front();
               if (rsp_tdata[15:0] !== want.roll || rsp_tdata[30:16] !== want.pitch ||
                   rsp_tdata[46:31] !== want.yaw || rsp_tuser !== want.clamped) begin
                  if (error_count < 10)
                     $display("mismatch: exp roll %h pitch %h yaw %h clamp %b, got %h/%h/%h/%b",
                              want.roll, want.pitch, want.yaw, want.clamped, rsp_tdata[15:0],
                              rsp_tdata[30:16], rsp_tdata[46:31], rsp_tuser);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end
endmodule

// ===== sim/tb.sv =====
// Testbench top for the quaternion to Euler unit: stimulus, reset and verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY     = 72;
   localparam int STALL_LIMIT = 5000;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic [qte_pkg::IN_DATA_W-1:0]  req_tdata = '0;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [qte_pkg::OUT_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tuser;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic                           csr_wr_en = 1'b0;
   logic                           csr_wr_data = 1'b0;
   int                             error_count;
   int                             pending_count;
   bit                             steady_phase = 1'b0;   // no idling on either side
   int                             quiet_cycles = 0;

   quaternion_to_euler_zyx_unit dut (.*);

   qte_checker checker_i (.*);

   initial forever #2 clock = ~clock;

   // Randomly stall the response side, except during the steady stretch.
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else       rsp_tready <= steady_phase || ($urandom_range(99) >= 30);
   end

   // Watchdog: count cycles in which neither channel moves anything.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic logic [15:0] rand_elem();
      int pick;
      pick = $urandom_range(9);
      if (pick == 0) return 16'($urandom());               // raw, any bit pattern
      if (pick == 1) return ($urandom_range(1)) ? 16'sd16384 : -16'sd16384;
      if (pick == 2) return 16'($signed($urandom_range(64)) - 32);
      return 16'($signed($urandom_range(32768)) - 16384);
   endfunction

   // Build a roughly unit quaternion with random direction.
   function automatic logic [qte_pkg::IN_DATA_W-1:0] unit_quat();
      real c [4];
      real n;
      logic [qte_pkg::IN_DATA_W-1:0] d;
      n = 0.0;
      for (int i = 0; i < 4; i++) begin
         c[i] = (real'($urandom_range(20000)) - 10000.0);
         n += c[i] * c[i];
      end
      if (n < 1.0) return {16'd0, 16'd0, 16'd0, 16'sd16384};
      n = $sqrt(n);
      for (int i = 0; i < 4; i++) d[16*i +: 16] = 16'($rtoi(c[i] / n * 16384.0));
      return d;
   endfunction

   // Send one request, idling at random before it unless steady; valid stays
   // high after acceptance until the next idle cycle or the drain.
   task automatic send_req(logic [qte_pkg::IN_DATA_W-1:0] d);
      while (!steady_phase && $urandom_range(99) < 30) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= d;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // Wait until every expected response has come, then let the pipe drain.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_order(logic w_last);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= w_last;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
   endtask

   task automatic directed_set();
      send_req({16'd0, 16'd0, 16'd0, 16'sd16384});          // identity
      send_req({16'd0, 16'd0, 16'd0, 16'd0});               // all zero elements
      send_req({16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}); // most negative raw
      send_req({16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF}); // most positive raw
      send_req({16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384});
      send_req({-16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384});
      send_req({16'd0, 16'd11585, 16'd0, 16'd11585});        // pitch near +90
      send_req({16'd0, -16'sd11585, 16'd0, 16'd11585});      // pitch near -90
      send_req({16'd0, 16'd16384, 16'd16384, 16'd0});        // zero sine argument
      send_req({16'd0, -16'sd16384, 16'd16384, 16'd0});
      send_req({16'd0, 16'd0, 16'd16384, 16'd0});            // zero num, negative den: pi
      send_req({16'd16384, 16'd0, 16'd0, 16'd0});
      send_req({16'd0, 16'd16384, 16'd0, 16'd0});
      send_req({16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA});
      send_req({16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555});
   endtask

   task automatic random_set(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(3) != 0)
            send_req(unit_quat());
         else
            send_req({rand_elem(), rand_elem(), rand_elem(), rand_elem()});
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Scalar first (reset value).
      directed_set();
      random_set(400);
      drain();

      write_order(1'b1);
      directed_set();
      random_set(400);
      steady_phase <= 1'b1;            // long stretch without idling
      random_set(300);
      steady_phase <= 1'b0;
      drain();

      write_order(1'b0);
      random_set(400);
      drain();

      write_order(1'b1);
      random_set(300);
      drain();

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
